// ===== src/stcm_pkg.sv =====
`default_nettype none

package stcm_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int COLOR_WIDTH     = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam int DIFF_WIDTH     = SAMPLE_WIDTH + 1;
    localparam int BAND_WIDTH     = 3;
    localparam int BAND_REM_WIDTH = SAMPLE_WIDTH + BAND_WIDTH;
    localparam int FRAC_REM_WIDTH = SAMPLE_WIDTH + COLOR_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PALETTE    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = CFG_INDEX_WIDTH'(2);

    localparam logic PAL_TRAFFIC = 1'b0;
    localparam logic PAL_SEVEN   = 1'b1;

    localparam logic [SAMPLE_WIDTH-1:0] RANGE_LOW_RESET  = '0;
    localparam logic [SAMPLE_WIDTH-1:0] RANGE_HIGH_RESET = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    localparam logic [COLOR_WIDTH-1:0] C_FULL = '1;
    localparam logic [COLOR_WIDTH-1:0] C_HALF = {1'b1, {(COLOR_WIDTH-1){1'b0}}};
    localparam logic [COLOR_WIDTH-1:0] C_ZERO = '0;

    localparam logic [BAND_WIDTH-1:0] BAND_W2M = BAND_WIDTH'(1);
    localparam logic [BAND_WIDTH-1:0] BAND_M2B = BAND_WIDTH'(2);
    localparam logic [BAND_WIDTH-1:0] BAND_B2C = BAND_WIDTH'(3);
    localparam logic [BAND_WIDTH-1:0] BAND_C2G = BAND_WIDTH'(4);
    localparam logic [BAND_WIDTH-1:0] BAND_G2Y = BAND_WIDTH'(5);
    localparam logic [BAND_WIDTH-1:0] BAND_Y2R = BAND_WIDTH'(6);
    localparam logic [BAND_WIDTH-1:0] BAND_R2K = BAND_WIDTH'(7);

    typedef enum logic [2:0] {
        KIND_RAMP    = 3'd0,
        KIND_WHITE   = 3'd1,
        KIND_GREY    = 3'd2,
        KIND_DARKRED = 3'd3,
        KIND_GREEN   = 3'd4,
        KIND_BLACK   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic                  palette;
        logic                  lower_half;
        logic [BAND_WIDTH-1:0] band;
    } t_side;

    typedef struct packed {
        logic [COLOR_WIDTH-1:0] red;
        logic [COLOR_WIDTH-1:0] green;
        logic [COLOR_WIDTH-1:0] blue;
    } t_color;

endpackage

`default_nettype wire

// ===== src/stcm_classify.sv =====
`default_nettype none

module stcm_classify (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire logic                                     i_valid,
    input  wire logic signed [stcm_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                                     i_palette,
    input  wire logic signed [stcm_pkg::SAMPLE_WIDTH-1:0] i_range_low,
    input  wire logic signed [stcm_pkg::SAMPLE_WIDTH-1:0] i_range_high,
    output logic                                          o_valid,
    output stcm_pkg::t_side                               o_side,
    output logic [stcm_pkg::SAMPLE_WIDTH-1:0]             o_d,
    output logic [stcm_pkg::SAMPLE_WIDTH-1:0]             o_x
);

    logic signed [stcm_pkg::DIFF_WIDTH-1:0] v;
    logic signed [stcm_pkg::DIFF_WIDTH-1:0] lo;
    logic signed [stcm_pkg::DIFF_WIDTH-1:0] hi;
    logic signed [stcm_pkg::DIFF_WIDTH-1:0] d_full;
    logic signed [stcm_pkg::DIFF_WIDTH-1:0] x_full;
    logic below;
    logic above;
    logic empty;
    logic inverted;
    stcm_pkg::t_side n_side;

    logic r_valid;
    stcm_pkg::t_side r_side;
    logic [stcm_pkg::SAMPLE_WIDTH-1:0] r_d;
    logic [stcm_pkg::SAMPLE_WIDTH-1:0] r_x;

    assign v  = {i_sample[stcm_pkg::SAMPLE_WIDTH-1], i_sample};
    assign lo = {i_range_low[stcm_pkg::SAMPLE_WIDTH-1], i_range_low};
    assign hi = {i_range_high[stcm_pkg::SAMPLE_WIDTH-1], i_range_high};

    assign d_full   = hi - lo;
    assign x_full   = v - lo;
    assign below    = v < lo;
    assign above    = v > hi;
    assign empty    = lo == hi;
    assign inverted = lo >= hi;

    always_comb begin
        n_side         = '0;
        n_side.palette = i_palette;
        n_side.kind    = stcm_pkg::KIND_RAMP;
        if (i_palette == stcm_pkg::PAL_SEVEN) begin
            if (inverted) begin
                n_side.kind = stcm_pkg::KIND_GREY;
            end else if (below) begin
                n_side.kind = stcm_pkg::KIND_WHITE;
            end else if (above) begin
                n_side.kind = stcm_pkg::KIND_BLACK;
            end
        end else begin
            if (empty) begin
                n_side.kind = stcm_pkg::KIND_WHITE;
            end else if (below) begin
                n_side.kind = stcm_pkg::KIND_DARKRED;
            end else if (above) begin
                n_side.kind = stcm_pkg::KIND_GREEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_d    <= d_full[stcm_pkg::SAMPLE_WIDTH-1:0];
            r_x    <= x_full[stcm_pkg::SAMPLE_WIDTH-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_d     = r_d;
    assign o_x     = r_x;

endmodule

`default_nettype wire

// ===== src/stcm_band.sv =====
`default_nettype none

module stcm_band (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire stcm_pkg::t_side                      i_side,
    input  wire logic [stcm_pkg::SAMPLE_WIDTH-1:0]    i_d,
    input  wire logic [stcm_pkg::SAMPLE_WIDTH-1:0]    i_x,
    output logic                                      o_valid,
    output stcm_pkg::t_side                           o_side,
    output logic [stcm_pkg::SAMPLE_WIDTH-1:0]         o_d,
    output logic [stcm_pkg::SAMPLE_WIDTH-1:0]         o_n
);

    localparam int W  = stcm_pkg::SAMPLE_WIDTH;
    localparam int BW = stcm_pkg::BAND_REM_WIDTH;
    localparam int NB = stcm_pkg::BAND_WIDTH;

    logic [BW-1:0] x7;
    logic [W:0]    x2;
    logic          lower;
    logic [W-1:0]  tn;
    logic [W-1:0]  dmx;
    stcm_pkg::t_side side0;

    logic                 in_valid [NB];
    logic [BW-1:0]        in_rem   [NB];
    logic [NB-1:0]        in_q     [NB];
    logic [W-1:0]         in_d     [NB];
    logic [W-1:0]         in_tn    [NB];
    stcm_pkg::t_side      in_side  [NB];

    logic                 r_valid [NB];
    logic [BW-1:0]        r_rem   [NB];
    logic [NB-1:0]        r_q     [NB];
    logic [W-1:0]         r_d     [NB];
    logic [W-1:0]         r_tn    [NB];
    stcm_pkg::t_side      r_side  [NB];

    logic            exact;
    logic [W-1:0]    rem_sel;
    stcm_pkg::t_side n_sel_side;
    logic [W-1:0]    n_sel_n;

    logic            r_sel_valid;
    stcm_pkg::t_side r_sel_side;
    logic [W-1:0]    r_sel_d;
    logic [W-1:0]    r_sel_n;

    assign x7    = {i_x, {NB{1'b0}}} - {{NB{1'b0}}, i_x};
    assign x2    = {i_x, 1'b0};
    assign lower = x2 <= {1'b0, i_d};
    assign dmx   = i_d - i_x;
    assign tn    = lower ? x2[W-1:0] : {dmx[W-2:0], 1'b0};

    always_comb begin
        side0            = i_side;
        side0.lower_half = lower;
    end

    for (genvar s = 0; s < NB; s++) begin : g_step
        logic [BW-1:0] dsh;
        logic          ge;

        if (s == 0) begin : g_first
            assign in_valid[s] = i_valid;
            assign in_rem[s]   = x7;
            assign in_q[s]     = '0;
            assign in_d[s]     = i_d;
            assign in_tn[s]    = tn;
            assign in_side[s]  = side0;
        end else begin : g_next
            assign in_valid[s] = r_valid[s-1];
            assign in_rem[s]   = r_rem[s-1];
            assign in_q[s]     = r_q[s-1];
            assign in_d[s]     = r_d[s-1];
            assign in_tn[s]    = r_tn[s-1];
            assign in_side[s]  = r_side[s-1];
        end

        assign dsh = BW'(in_d[s]) << (NB - 1 - s);
        assign ge  = in_rem[s] >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= in_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? in_rem[s] - dsh : in_rem[s];
                r_q[s]    <= {in_q[s][NB-2:0], ge};
                r_d[s]    <= in_d[s];
                r_tn[s]   <= in_tn[s];
                r_side[s] <= in_side[s];
            end
        end
    end

    // A sample on a band boundary stays in the lower band with a full ramp.
    assign exact   = (r_rem[NB-1] == '0) && (r_q[NB-1] != '0);
    assign rem_sel = exact ? r_d[NB-1] : r_rem[NB-1][W-1:0];

    always_comb begin
        n_sel_side      = r_side[NB-1];
        n_sel_side.band = exact ? r_q[NB-1] : r_q[NB-1] + NB'(1);
        n_sel_n         = (r_side[NB-1].palette == stcm_pkg::PAL_SEVEN) ? rem_sel
                                                                       : r_tn[NB-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid <= 1'b0;
        end else if (i_en) begin
            r_sel_valid <= r_valid[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel_side <= n_sel_side;
            r_sel_d    <= r_d[NB-1];
            r_sel_n    <= n_sel_n;
        end
    end

    assign o_valid = r_sel_valid;
    assign o_side  = r_sel_side;
    assign o_d     = r_sel_d;
    assign o_n     = r_sel_n;

endmodule

`default_nettype wire

// ===== src/stcm_frac.sv =====
`default_nettype none

module stcm_frac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire stcm_pkg::t_side                   i_side,
    input  wire logic [stcm_pkg::SAMPLE_WIDTH-1:0] i_d,
    input  wire logic [stcm_pkg::SAMPLE_WIDTH-1:0] i_n,
    output logic                                   o_valid,
    output stcm_pkg::t_side                        o_side,
    output logic [stcm_pkg::COLOR_WIDTH-1:0]       o_q,
    output logic                                   o_nz
);

    localparam int W  = stcm_pkg::SAMPLE_WIDTH;
    localparam int CW = stcm_pkg::COLOR_WIDTH;
    localparam int RW = stcm_pkg::FRAC_REM_WIDTH;

    logic [RW-1:0] scaled;

    logic            in_valid [CW];
    logic [RW-1:0]   in_rem   [CW];
    logic [CW-1:0]   in_q     [CW];
    logic [W-1:0]    in_d     [CW];
    stcm_pkg::t_side in_side  [CW];

    logic            r_valid [CW];
    logic [RW-1:0]   r_rem   [CW];
    logic [CW-1:0]   r_q     [CW];
    logic [W-1:0]    r_d     [CW];
    stcm_pkg::t_side r_side  [CW];

    assign scaled = {i_n, {CW{1'b0}}} - {{CW{1'b0}}, i_n};

    for (genvar s = 0; s < CW; s++) begin : g_step
        logic [RW-1:0] dsh;
        logic          ge;

        if (s == 0) begin : g_first
            assign in_valid[s] = i_valid;
            assign in_rem[s]   = scaled;
            assign in_q[s]     = '0;
            assign in_d[s]     = i_d;
            assign in_side[s]  = i_side;
        end else begin : g_next
            assign in_valid[s] = r_valid[s-1];
            assign in_rem[s]   = r_rem[s-1];
            assign in_q[s]     = r_q[s-1];
            assign in_d[s]     = r_d[s-1];
            assign in_side[s]  = r_side[s-1];
        end

        assign dsh = RW'(in_d[s]) << (CW - 1 - s);
        assign ge  = in_rem[s] >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= in_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? in_rem[s] - dsh : in_rem[s];
                r_q[s]    <= {in_q[s][CW-2:0], ge};
                r_d[s]    <= in_d[s];
                r_side[s] <= in_side[s];
            end
        end
    end

    assign o_valid = r_valid[CW-1];
    assign o_side  = r_side[CW-1];
    assign o_q     = r_q[CW-1];
    assign o_nz    = r_rem[CW-1] != '0;

endmodule

`default_nettype wire

// ===== src/stcm_color.sv =====
`default_nettype none

module stcm_color (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire stcm_pkg::t_side                  i_side,
    input  wire logic [stcm_pkg::COLOR_WIDTH-1:0] i_q,
    input  wire logic                             i_nz,
    input  wire logic                             i_ready,
    output logic                                  o_en,
    output logic                                  o_valid,
    output stcm_pkg::t_color                      o_color
);

    localparam int CW = stcm_pkg::COLOR_WIDTH;

    logic [CW-1:0]     up;
    logic [CW-1:0]     down;
    logic              take;
    logic              drain;
    stcm_pkg::t_color  n_color;

    logic              r_out_valid;
    logic              r_skid_valid;
    stcm_pkg::t_color  r_out_color;
    stcm_pkg::t_color  r_skid_color;

    // The falling ramp is the full scale minus the rounded-up rising ramp.
    assign up   = i_q;
    assign down = stcm_pkg::C_FULL - i_q - {{(CW-1){1'b0}}, i_nz};

    always_comb begin
        n_color = '{stcm_pkg::C_ZERO, stcm_pkg::C_ZERO, stcm_pkg::C_ZERO};
        case (i_side.kind)
            stcm_pkg::KIND_WHITE: begin
                n_color = '{stcm_pkg::C_FULL, stcm_pkg::C_FULL, stcm_pkg::C_FULL};
            end
            stcm_pkg::KIND_GREY: begin
                n_color = '{stcm_pkg::C_HALF, stcm_pkg::C_HALF, stcm_pkg::C_HALF};
            end
            stcm_pkg::KIND_DARKRED: begin
                n_color = '{stcm_pkg::C_HALF, stcm_pkg::C_ZERO, stcm_pkg::C_ZERO};
            end
            stcm_pkg::KIND_GREEN: begin
                n_color = '{stcm_pkg::C_ZERO, stcm_pkg::C_FULL, stcm_pkg::C_ZERO};
            end
            stcm_pkg::KIND_BLACK: begin
                n_color = '{stcm_pkg::C_ZERO, stcm_pkg::C_ZERO, stcm_pkg::C_ZERO};
            end
            stcm_pkg::KIND_RAMP: begin
                if (i_side.palette == stcm_pkg::PAL_TRAFFIC) begin
                    if (i_side.lower_half) begin
                        n_color = '{stcm_pkg::C_FULL, up, stcm_pkg::C_ZERO};
                    end else begin
                        n_color = '{up, stcm_pkg::C_FULL, stcm_pkg::C_ZERO};
                    end
                end else begin
                    case (i_side.band)
                        stcm_pkg::BAND_W2M: begin
                            n_color = '{stcm_pkg::C_FULL, down, stcm_pkg::C_FULL};
                        end
                        stcm_pkg::BAND_M2B: begin
                            n_color = '{down, stcm_pkg::C_ZERO, stcm_pkg::C_FULL};
                        end
                        stcm_pkg::BAND_B2C: begin
                            n_color = '{stcm_pkg::C_ZERO, up, stcm_pkg::C_FULL};
                        end
                        stcm_pkg::BAND_C2G: begin
                            n_color = '{stcm_pkg::C_ZERO, stcm_pkg::C_FULL, down};
                        end
                        stcm_pkg::BAND_G2Y: begin
                            n_color = '{up, stcm_pkg::C_FULL, stcm_pkg::C_ZERO};
                        end
                        stcm_pkg::BAND_Y2R: begin
                            n_color = '{stcm_pkg::C_FULL, down, stcm_pkg::C_ZERO};
                        end
                        stcm_pkg::BAND_R2K: begin
                            n_color = '{down, stcm_pkg::C_ZERO, stcm_pkg::C_ZERO};
                        end
                        default: begin
                            n_color = '{stcm_pkg::C_ZERO, stcm_pkg::C_ZERO,
                                        stcm_pkg::C_ZERO};
                        end
                    endcase
                end
            end
            default: begin
                n_color = '{stcm_pkg::C_ZERO, stcm_pkg::C_ZERO, stcm_pkg::C_ZERO};
            end
        endcase
    end

    // The pipeline moves whenever the skid entry is free.
    assign o_en  = !r_skid_valid;
    assign take  = o_en && i_valid;
    assign drain = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= take;
            end
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out_color <= r_skid_valid ? r_skid_color : n_color;
        end else if (take) begin
            r_skid_color <= n_color;
        end
    end

    assign o_valid = r_out_valid;
    assign o_color = r_out_color;

endmodule

`default_nettype wire

// ===== src/scalar_to_rgb_colormap_core.sv =====
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_sample
// output    out        o_out_valid / i_out_ready    o_red, o_green, o_blue
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One sample request is taken every cycle unless back pressure fills the output
// buffer; each result passes one classify stage, three band-search stages, one band
// select stage, one divider stage per color bit and the output register.
// A two-entry output buffer lets the pipeline keep moving until it fills.
// Reset restores the palette to traffic and the range to zero through 32767.
`default_nettype none

module scalar_to_rgb_colormap_core (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_in_valid,
    output logic                                             o_in_ready,
    input  wire logic signed [stcm_pkg::SAMPLE_WIDTH-1:0]    i_sample,
    output logic                                             o_out_valid,
    input  wire logic                                        i_out_ready,
    output logic [stcm_pkg::COLOR_WIDTH-1:0]                 o_red,
    output logic [stcm_pkg::COLOR_WIDTH-1:0]                 o_green,
    output logic [stcm_pkg::COLOR_WIDTH-1:0]                 o_blue,
    input  wire logic                                        i_cfg_valid,
    output logic                                             o_cfg_ready,
    input  wire logic [stcm_pkg::CFG_INDEX_WIDTH-1:0]        i_cfg_index,
    input  wire logic [stcm_pkg::SAMPLE_WIDTH-1:0]           i_cfg_data
);

    logic r_palette;
    logic signed [stcm_pkg::SAMPLE_WIDTH-1:0] r_range_low;
    logic signed [stcm_pkg::SAMPLE_WIDTH-1:0] r_range_high;

    logic en;

    logic                              cls_valid;
    stcm_pkg::t_side                   cls_side;
    logic [stcm_pkg::SAMPLE_WIDTH-1:0] cls_d;
    logic [stcm_pkg::SAMPLE_WIDTH-1:0] cls_x;

    logic                              band_valid;
    stcm_pkg::t_side                   band_side;
    logic [stcm_pkg::SAMPLE_WIDTH-1:0] band_d;
    logic [stcm_pkg::SAMPLE_WIDTH-1:0] band_n;

    logic                              frac_valid;
    stcm_pkg::t_side                   frac_side;
    logic [stcm_pkg::COLOR_WIDTH-1:0]  frac_q;
    logic                              frac_nz;

    stcm_pkg::t_color                  color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette    <= stcm_pkg::PAL_TRAFFIC;
            r_range_low  <= stcm_pkg::RANGE_LOW_RESET;
            r_range_high <= stcm_pkg::RANGE_HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                stcm_pkg::REG_PALETTE: begin
                    r_palette <= i_cfg_data[0];
                end
                stcm_pkg::REG_RANGE_LOW: begin
                    r_range_low <= i_cfg_data;
                end
                stcm_pkg::REG_RANGE_HIGH: begin
                    r_range_high <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = en;

    stcm_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_sample     (i_sample),
        .i_palette    (r_palette),
        .i_range_low  (r_range_low),
        .i_range_high (r_range_high),
        .o_valid      (cls_valid),
        .o_side       (cls_side),
        .o_d          (cls_d),
        .o_x          (cls_x)
    );

    stcm_band u_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cls_valid),
        .i_side  (cls_side),
        .i_d     (cls_d),
        .i_x     (cls_x),
        .o_valid (band_valid),
        .o_side  (band_side),
        .o_d     (band_d),
        .o_n     (band_n)
    );

    stcm_frac u_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (band_valid),
        .i_side  (band_side),
        .i_d     (band_d),
        .i_n     (band_n),
        .o_valid (frac_valid),
        .o_side  (frac_side),
        .o_q     (frac_q),
        .o_nz    (frac_nz)
    );

    stcm_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (frac_valid),
        .i_side  (frac_side),
        .i_q     (frac_q),
        .i_nz    (frac_nz),
        .i_ready (i_out_ready),
        .o_en    (en),
        .o_valid (o_out_valid),
        .o_color (color)
    );

    assign o_red   = color.red;
    assign o_green = color.green;
    assign o_blue  = color.blue;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    import stcm_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = CFG_INDEX_WIDTH'(3);
    localparam int     PHASES        = 14;
    localparam int     PHASE_SAMPLES = 100;
    localparam int     LATENCY       = 14;
    localparam int     NUM_ROWS      = 36;
    localparam longint NUM_BANDS     = 7;
    localparam longint FULL_SCALE    = longint'(C_FULL);

    typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_op_e;

    typedef struct packed {
        row_op_e                    op;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [SAMPLE_WIDTH-1:0]    value;
        logic                       typed;
        t_color                     color;
    } stim_row_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        t_color                  color;
    } pending_t;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic [SAMPLE_WIDTH-1:0]    i_sample    = '0;
    logic                       i_out_ready = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [SAMPLE_WIDTH-1:0]    i_cfg_data  = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic                       o_cfg_ready;
    logic [COLOR_WIDTH-1:0]     o_red;
    logic [COLOR_WIDTH-1:0]     o_green;
    logic [COLOR_WIDTH-1:0]     o_blue;

    logic                              cfg_palette = PAL_TRAFFIC;
    logic signed [SAMPLE_WIDTH-1:0]    cfg_low     = RANGE_LOW_RESET;
    logic signed [SAMPLE_WIDTH-1:0]    cfg_high    = RANGE_HIGH_RESET;

    pending_t pending_colors [$];
    int in_gap_max      = 4;
    int out_stall_max   = 4;
    int fault_count     = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int writes_done     = 0;

    scalar_to_rgb_colormap_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_color colormap_of(logic signed [SAMPLE_WIDTH-1:0] s);
        longint v, lo, hi, d, x, k, rem, up, down;
        logic [BAND_WIDTH-1:0] band;
        t_color c;
        v = s;
        lo = cfg_low;
        hi = cfg_high;
        c = '{C_ZERO, C_ZERO, C_ZERO};
        if (cfg_palette == PAL_TRAFFIC) begin
            if (lo == hi) begin
                c = '{C_FULL, C_FULL, C_FULL};
            end else if (v < lo) begin
                c = '{C_HALF, C_ZERO, C_ZERO};
            end else if (v > hi) begin
                c = '{C_ZERO, C_FULL, C_ZERO};
            end else begin
                d = hi - lo;
                x = v - lo;
                if (2 * x <= d) begin
                    c = '{C_FULL, COLOR_WIDTH'(2 * x * FULL_SCALE / d), C_ZERO};
                end else begin
                    c = '{COLOR_WIDTH'(2 * (hi - v) * FULL_SCALE / d), C_FULL, C_ZERO};
                end
            end
        end else begin
            if (lo >= hi) begin
                c = '{C_HALF, C_HALF, C_HALF};
            end else if (v < lo) begin
                c = '{C_FULL, C_FULL, C_FULL};
            end else if (v > hi) begin
                c = '{C_ZERO, C_ZERO, C_ZERO};
            end else begin
                d = hi - lo;
                x = v - lo;
                // A sample on a boundary stays in the lower band.
                k = (NUM_BANDS * x + d - 1) / d;
                if (k < 1) k = 1;
                if (k > NUM_BANDS) k = NUM_BANDS;
                rem = NUM_BANDS * x - (k - 1) * d;
                up = rem * FULL_SCALE / d;
                down = (d - rem) * FULL_SCALE / d;
                band = BAND_WIDTH'(k);
                case (band)
                    BAND_W2M: c = '{C_FULL, COLOR_WIDTH'(down), C_FULL};
                    BAND_M2B: c = '{COLOR_WIDTH'(down), C_ZERO, C_FULL};
                    BAND_B2C: c = '{C_ZERO, COLOR_WIDTH'(up), C_FULL};
                    BAND_C2G: c = '{C_ZERO, C_FULL, COLOR_WIDTH'(down)};
                    BAND_G2Y: c = '{COLOR_WIDTH'(up), C_FULL, C_ZERO};
                    BAND_Y2R: c = '{C_FULL, COLOR_WIDTH'(down), C_ZERO};
                    default:  c = '{COLOR_WIDTH'(down), C_ZERO, C_ZERO};
                endcase
            end
        end
        return c;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_INDEX_WIDTH-1:0] idx,
                                          logic [SAMPLE_WIDTH-1:0] data);
        return '{ROW_WRITE, idx, data, 1'b0, '{C_ZERO, C_ZERO, C_ZERO}};
    endfunction

    function automatic stim_row_t sample_row(logic [SAMPLE_WIDTH-1:0] s);
        return '{ROW_SAMPLE, REG_PALETTE, s, 1'b0, '{C_ZERO, C_ZERO, C_ZERO}};
    endfunction

    function automatic stim_row_t known_row(logic [SAMPLE_WIDTH-1:0] s,
                                            logic [COLOR_WIDTH-1:0] r,
                                            logic [COLOR_WIDTH-1:0] g,
                                            logic [COLOR_WIDTH-1:0] b);
        return '{ROW_SAMPLE, REG_PALETTE, s, 1'b1, '{r, g, b}};
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(longint lo, longint hi);
        longint d, t;
        int r;
        d = hi - lo;
        r = $urandom_range(0, 99);
        if (r < 55 && d > 0) begin
            t = lo + longint'($urandom_range(0, int'(d)));
        end else if (r < 70 && d > 0) begin
            if ($urandom_range(0, 1) == 1) begin
                t = lo + (d * longint'($urandom_range(0, 7))) / NUM_BANDS;
            end else begin
                t = lo + d / 2;
            end
            t = t + longint'($urandom_range(0, 2)) - 1;
        end else if (r < 80) begin
            case ($urandom_range(0, 3))
                0: t = lo - 1;
                1: t = lo;
                2: t = hi;
                default: t = hi + 1;
            endcase
        end else begin
            t = longint'($urandom);
        end
        return SAMPLE_WIDTH'(t);
    endfunction

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [SAMPLE_WIDTH-1:0] s, logic typed, t_color known);
        int gap;
        pending_t entry;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        entry.sample = s;
        entry.color = typed ? known : colormap_of(s);
        pending_colors.push_back(entry);
        samples_sent++;
    endtask

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                  logic [SAMPLE_WIDTH-1:0] data);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_PALETTE:    cfg_palette = data[0];
            REG_RANGE_LOW:  cfg_low = data;
            REG_RANGE_HIGH: cfg_high = data;
            default: ;
        endcase
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int stall;
        t_color got;
        pending_t head;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = '{o_red, o_green, o_blue};
            results_checked++;
            if (pending_colors.size() == 0) begin
                if (fault_count < 10) begin
                    $display("Unexpected color %h %h %h with no request pending",
                             got.red, got.green, got.blue);
                end
                fault_count++;
            end else begin
                head = pending_colors.pop_front();
                if (got !== head.color) begin
                    if (fault_count < 10) begin
                        $display("Sample %0d: expected rgb %h %h %h, got %h %h %h",
                                 $signed(head.sample), head.color.red, head.color.green,
                                 head.color.blue, got.red, got.green, got.blue);
                    end
                    fault_count++;
                end
            end
        end
    end

    initial begin
        stim_row_t rows [NUM_ROWS];
        longint lo, hi, a, b;
        int p, n;
        rows = '{
            known_row(16'h0000, C_FULL, C_ZERO, C_ZERO),
            known_row(16'h8000, C_HALF, C_ZERO, C_ZERO),
            known_row(16'h7FFF, C_ZERO, C_FULL, C_ZERO),
            sample_row(16'd16383),
            sample_row(16'd16384),
            reg_row(REG_RANGE_LOW, 16'h8000),
            known_row(16'h8000, C_FULL, C_ZERO, C_ZERO),
            known_row(16'h7FFF, C_ZERO, C_FULL, C_ZERO),
            reg_row(REG_RANGE_LOW, 16'd100),
            reg_row(REG_RANGE_HIGH, 16'd100),
            known_row(16'd100, C_FULL, C_FULL, C_FULL),
            known_row(16'h8000, C_FULL, C_FULL, C_FULL),
            reg_row(REG_RANGE_LOW, 16'd200),
            known_row(16'd150, C_HALF, C_ZERO, C_ZERO),
            known_row(16'd300, C_ZERO, C_FULL, C_ZERO),
            known_row(16'd200, C_ZERO, C_FULL, C_ZERO),
            reg_row(REG_PALETTE, 16'hFFFF),
            reg_row(REG_RANGE_LOW, 16'd0),
            reg_row(REG_RANGE_HIGH, 16'd14),
            known_row(16'hFFFF, C_FULL, C_FULL, C_FULL),
            known_row(16'd15, C_ZERO, C_ZERO, C_ZERO),
            sample_row(16'd1),
            sample_row(16'd2),
            sample_row(16'd3),
            sample_row(16'd5),
            sample_row(16'd7),
            sample_row(16'd9),
            sample_row(16'd11),
            sample_row(16'd13),
            sample_row(16'd14),
            reg_row(REG_UNUSED, 16'h0000),
            sample_row(16'd4),
            reg_row(REG_RANGE_HIGH, 16'h0000),
            known_row(16'h0000, C_HALF, C_HALF, C_HALF),
            reg_row(REG_RANGE_HIGH, 16'hFFFB),
            known_row(16'h8000, C_HALF, C_HALF, C_HALF)
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (rows[i].op == ROW_WRITE) begin
                write_register(rows[i].index, rows[i].value);
            end else begin
                send_sample(rows[i].value, rows[i].typed, rows[i].color);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            case (p % 7)
                0: begin
                    lo = -32768;
                    hi = 32767;
                end
                1: begin
                    lo = longint'($urandom_range(0, 65515)) - 32768;
                    hi = lo + longint'($urandom_range(1, 20));
                end
                2: begin
                    a = longint'($signed(SAMPLE_WIDTH'($urandom)));
                    b = longint'($signed(SAMPLE_WIDTH'($urandom)));
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
                3: begin
                    lo = longint'($signed(SAMPLE_WIDTH'($urandom)));
                    hi = lo;
                end
                4: begin
                    a = longint'($signed(SAMPLE_WIDTH'($urandom)));
                    b = longint'($signed(SAMPLE_WIDTH'($urandom)));
                    lo = (a < b) ? b : a;
                    hi = (a < b) ? a : b;
                end
                5: begin
                    lo = 32767 - longint'($urandom_range(1, 7));
                    hi = 32767;
                end
                default: begin
                    lo = longint'($urandom_range(0, 32000)) - 32768;
                    hi = lo + longint'($urandom_range(7, 300));
                end
            endcase

            write_register(REG_PALETTE, SAMPLE_WIDTH'(($urandom & 32'hFFFE) | (p % 2)));
            write_register(REG_RANGE_LOW, SAMPLE_WIDTH'(lo));
            if (p % 3 == 0) write_register(REG_UNUSED, SAMPLE_WIDTH'($urandom));
            write_register(REG_RANGE_HIGH, SAMPLE_WIDTH'(hi));

            in_gap_max = (p % 5 == 2 || p % 5 == 4) ? 0 : 4;
            out_stall_max = (p % 5 == 3 || p % 5 == 4) ? 0 : 4;

            for (n = 0; n < PHASE_SAMPLES; n++) begin
                if (n == PHASE_SAMPLES / 2 && p % 4 == 1) wait_for_results();
                send_sample(pick_sample(lo, hi), 1'b0, '{C_ZERO, C_ZERO, C_ZERO});
            end
        end

        wait_for_results();
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Checked %0d colors from %0d samples and %0d register writes.",
                 results_checked, samples_sent, writes_done);
        $display("Both palettes over full, narrow, empty and inverted ranges; %0d faults.",
                 fault_count);
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/stcm_pkg.sv
src/stcm_classify.sv
src/stcm_band.sv
src/stcm_frac.sv
src/stcm_color.sv
src/scalar_to_rgb_colormap_core.sv
test/testbench.sv
